[src/dlce_pkg.sv]
package dlce_pkg;

  // Operation codes of an input word
  typedef enum logic [2:0] {
    OP_INDEX_WR   = 3'd0,
    OP_PAGED_WR   = 3'd1,
    OP_DIRECT_WR  = 3'd2,
    OP_INDEX_RD   = 3'd3,
    OP_PAGED_RD   = 3'd4,
    OP_INVALIDATE = 3'd5
  } op_t;

  localparam int unsigned WORDS_MAX = 4;

  // Link word prefixes and fixed words
  localparam logic [7:0]  PFX_INDEX_DATA  = 8'h81;
  localparam logic [7:0]  PFX_REG_DATA    = 8'h01;
  localparam logic [7:0]  PFX_DIRECT_DATA = 8'hC1;
  localparam logic [1:0]  PFX_DIRECT_ADDR = 2'b11;
  localparam logic        PFX_INDEX_ADDR  = 1'b1;
  localparam logic [7:0]  REG_PAGE_SEL    = 8'hEF;
  localparam logic [15:0] WORD_INDEX_RD   = 16'hA000;
  localparam logic [15:0] WORD_PAGED_RD   = 16'h2000;

  // Words queued for one input item: slot 0 goes out first
  typedef struct packed {
    logic [WORDS_MAX-1:0][15:0] words;
    logic [WORDS_MAX-1:0]       is_data;
    logic [1:0]                 last_idx;
  } plan_t;

endpackage

[src/dlce_if.sv]
interface dlce_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [14:0] index_address;
  logic [7:0]  page;
  logic [7:0]  register_index;
  logic [13:0] command_address;
  logic [7:0]  data_byte;
  logic        run_end;

  modport source (
    output valid, operation, index_address, page, register_index,
           command_address, data_byte, run_end,
    input  ready
  );
  modport sink (
    input  valid, operation, index_address, page, register_index,
           command_address, data_byte, run_end,
    output ready
  );
endinterface

interface dlce_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] link_word;
  logic        reply_is_data;
  logic        last;

  modport source (output valid, link_word, reply_is_data, last, input ready);
  modport sink   (input valid, link_word, reply_is_data, last, output ready);
endinterface

[src/dlce_fifo.sv]
module dlce_fifo import dlce_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  plan_t plan_in,
  input  logic  pop,
  output plan_t plan_out,
  output logic  full,
  output logic  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  plan_t           mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CW-1:0]   cnt_r;
  logic [CW-1:0]   cnt_nxt;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign plan_out = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= plan_in;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("queue read while empty");

endmodule

[src/dlce_front.sv]
module dlce_front import dlce_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  dlce_in_if.sink     in_item,
  input  logic        q_full,
  output logic        q_push,
  output plan_t       q_plan
);

  logic [15:0] idx_cache_r, idx_cache_nxt;
  logic        idx_valid_r, idx_valid_nxt;
  logic [7:0]  pg_cache_r,  pg_cache_nxt;
  logic        pg_valid_r,  pg_valid_nxt;
  logic [8:0]  reg_cache_r, reg_cache_nxt;
  logic        reg_valid_r, reg_valid_nxt;

  logic        fire;
  logic        page_hit;
  logic        reg_hit;
  logic        idx_hit;
  logic [2:0]  n;
  plan_t       plan;

  assign in_item.ready = !q_full;
  assign fire          = in_item.valid && in_item.ready;
  assign q_push        = fire && (n != 3'd0);
  assign q_plan        = plan;

  assign page_hit = pg_valid_r && (pg_cache_r == in_item.page);
  assign idx_hit  = idx_valid_r && (idx_cache_r == {1'b0, in_item.index_address});

  always_comb begin
    idx_cache_nxt = idx_cache_r;
    idx_valid_nxt = idx_valid_r;
    pg_cache_nxt  = pg_cache_r;
    pg_valid_nxt  = pg_valid_r;
    reg_cache_nxt = reg_cache_r;
    reg_valid_nxt = reg_valid_r;
    reg_hit       = reg_valid_r && (reg_cache_r == {1'b0, in_item.register_index});
    plan          = '0;
    n             = 3'd0;
    case (op_t'(in_item.operation))
      OP_INDEX_WR: begin
        if (!idx_hit) begin
          plan.words[n[1:0]] = {PFX_INDEX_ADDR, in_item.index_address};
          n = n + 3'd1;
        end
        plan.words[n[1:0]] = {PFX_INDEX_DATA, in_item.data_byte};
        n = n + 3'd1;
        idx_cache_nxt = {1'b0, in_item.index_address} + 16'd1;
        idx_valid_nxt = 1'b1;
        reg_valid_nxt = 1'b0;
      end
      OP_PAGED_WR: begin
        // page select is itself a register: no page words for it
        if (!page_hit && (in_item.register_index != REG_PAGE_SEL)) begin
          plan.words[n[1:0]] = {8'h00, REG_PAGE_SEL};
          n = n + 3'd1;
          plan.words[n[1:0]] = {PFX_REG_DATA, in_item.page};
          n = n + 3'd1;
          pg_cache_nxt = in_item.page;
          pg_valid_nxt = 1'b1;
          reg_hit      = 1'b0;
        end
        if (!reg_hit) begin
          plan.words[n[1:0]] = {8'h00, in_item.register_index};
          n = n + 3'd1;
        end
        plan.words[n[1:0]] = {PFX_REG_DATA, in_item.data_byte};
        n = n + 3'd1;
        if (in_item.register_index == REG_PAGE_SEL) begin
          pg_cache_nxt = in_item.data_byte;
          pg_valid_nxt = 1'b1;
        end
        reg_cache_nxt = {1'b0, in_item.register_index} + 9'd1;
        reg_valid_nxt = 1'b1;
        idx_valid_nxt = 1'b0;
      end
      OP_DIRECT_WR: begin
        plan.words[0] = {PFX_DIRECT_ADDR, in_item.command_address};
        plan.words[1] = {PFX_DIRECT_DATA, in_item.data_byte};
        n = 3'd2;
        idx_valid_nxt = 1'b0;
        reg_valid_nxt = 1'b0;
      end
      OP_INDEX_RD: begin
        plan.words[0]   = {PFX_INDEX_ADDR, in_item.index_address};
        plan.words[1]   = WORD_INDEX_RD;
        plan.is_data[1] = 1'b1;
        n = 3'd2;
        idx_cache_nxt = {1'b0, in_item.index_address};
        idx_valid_nxt = 1'b1;
        reg_valid_nxt = 1'b0;
      end
      OP_PAGED_RD: begin
        if (!page_hit) begin
          plan.words[n[1:0]] = {8'h00, REG_PAGE_SEL};
          n = n + 3'd1;
          plan.words[n[1:0]] = {PFX_REG_DATA, in_item.page};
          n = n + 3'd1;
          pg_cache_nxt = in_item.page;
          pg_valid_nxt = 1'b1;
        end
        plan.words[n[1:0]] = {8'h00, in_item.register_index};
        n = n + 3'd1;
        plan.words[n[1:0]]   = WORD_PAGED_RD;
        plan.is_data[n[1:0]] = 1'b1;
        n = n + 3'd1;
        reg_cache_nxt = {1'b0, in_item.register_index};
        reg_valid_nxt = 1'b1;
        idx_valid_nxt = 1'b0;
      end
      OP_INVALIDATE: begin
        idx_valid_nxt = 1'b0;
        pg_valid_nxt  = 1'b0;
        reg_valid_nxt = 1'b0;
      end
      default: begin
      end
    endcase
    plan.last_idx = n[1:0] - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_cache_r <= '0;
      idx_valid_r <= 1'b0;
      pg_cache_r  <= '0;
      pg_valid_r  <= 1'b0;
      reg_cache_r <= '0;
      reg_valid_r <= 1'b0;
    end else if (fire) begin
      idx_cache_r <= idx_cache_nxt;
      idx_valid_r <= idx_valid_nxt;
      pg_cache_r  <= pg_cache_nxt;
      pg_valid_r  <= pg_valid_nxt;
      reg_cache_r <= reg_cache_nxt;
      reg_valid_r <= reg_valid_nxt;
    end
  end

  a_invalidate_clears: assert property (@(posedge clk) disable iff (!rst_n)
      (fire && in_item.operation == OP_INVALIDATE)
      |=> (!idx_valid_r && !pg_valid_r && !reg_valid_r))
    else $error("invalidate left a cache valid");

endmodule

[src/dlce_back.sv]
module dlce_back import dlce_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  plan_t       q_plan,
  input  logic        q_empty,
  output logic        q_pop,
  dlce_out_if.source  out_word
);

  plan_t       cur_r;
  logic [1:0]  idx_r;
  logic        busy_r;
  logic        fire;
  logic        at_last;
  logic        done;

  assign at_last = (idx_r == cur_r.last_idx);
  assign fire    = out_word.valid && out_word.ready;
  assign done    = !busy_r || (fire && at_last);
  assign q_pop   = done && !q_empty;

  assign out_word.valid         = busy_r;
  assign out_word.link_word     = cur_r.words[idx_r];
  assign out_word.reply_is_data = cur_r.is_data[idx_r];
  assign out_word.last          = at_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (done) begin
      busy_r <= !q_empty;
      idx_r  <= '0;
    end else if (fire) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_plan;
    end
  end

  a_data_word: assert property (@(posedge clk) disable iff (!rst_n)
      (out_word.valid && out_word.reply_is_data)
      |-> (out_word.link_word == WORD_INDEX_RD || out_word.link_word == WORD_PAGED_RD))
    else $error("data reply marked on a non read-out word");
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
      (fire && !out_word.last) |=> out_word.valid)
    else $error("item words broken off before last");

endmodule

[src/display_link_command_encoder_unit.sv]
// The first link word of an item is offered once its plan is written into the queue and
// then loaded into the back's plan register. Throughput: one link word per cycle while
//   the link is ready and plans wait; an item causes one to four words or none.
// The plan queue between front and back sets how far input may run ahead of the link.
// Reset (rst_n low, synchronous): all caches invalid and zero, queue and output empty.
module display_link_command_encoder_unit import dlce_pkg::*; #(
  parameter int FIFO_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  dlce_in_if.sink     in_item,
  dlce_out_if.source  out_word
);

  // Plan of words handed from front to back, one entry per item that causes a word
  plan_t push_plan;
  plan_t pop_plan;
  logic  push;
  logic  pop;
  logic  q_full;
  logic  q_empty;

  // Front: take the word, check the index, page and register caches,
  // build the list of link words and update the caches at once.
  dlce_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_item (in_item),
    .q_full  (q_full),
    .q_push  (push),
    .q_plan  (push_plan)
  );

  // Queue: decouple classification from the link so each side stalls alone.
  dlce_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .plan_in  (push_plan),
    .pop      (pop),
    .plan_out (pop_plan),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Back: hold one plan and advance through its words, one per handshake.
  dlce_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_plan   (pop_plan),
    .q_empty  (q_empty),
    .q_pop    (pop),
    .out_word (out_word)
  );

endmodule

[tb/display_link_command_encoder_unit_tb.sv]
`timescale 1ns / 100ps

module display_link_command_encoder_unit_tb;
  import dlce_pkg::*;

  // Spare operation codes: the block must take these words and send nothing
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  localparam int unsigned LIMIT        = 400_000;
  localparam int          RANDOM_WORDS = 250;

  // One panel access as offered on the input channel. A directed row may carry
  // up to two link words typed in by hand; those stand in for the predictor.
  typedef struct packed {
    logic [2:0]       operation;
    logic [14:0]      index_address;
    logic [7:0]       page;
    logic [7:0]       register_index;
    logic [13:0]      command_address;
    logic [7:0]       data_byte;
    logic             run_end;
    logic             typed;
    logic [1:0]       typed_count;
    logic [1:0][15:0] typed_words;
    logic [1:0]       typed_data;
  } panel_access_t;

  typedef struct packed {
    logic [15:0] word;
    logic        reply_is_data;
    logic        last;
  } link_exp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        out_ready = 1'b0;
  int unsigned cycles = 0;
  int          mismatches = 0;
  int          live_words = 0;
  int          stall_left = 0;

  panel_access_t access_plan[$];
  link_exp_t     link_words_due[$];
  panel_access_t offered_row = '0;

  // Shadow copies of the panel's index, page and register pointers
  logic [15:0] index_copy = '0;
  logic        index_copy_ok = 1'b0;
  logic [7:0]  page_copy = '0;
  logic        page_copy_ok = 1'b0;
  logic [8:0]  reg_copy = '0;
  logic        reg_copy_ok = 1'b0;

  dlce_in_if  in_item();
  dlce_out_if out_word();

  display_link_command_encoder_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .out_word (out_word)
  );

  // Hold every input at a known value from time zero
  assign in_item.valid           = in_valid;
  assign in_item.operation       = offered_row.operation;
  assign in_item.index_address   = offered_row.index_address;
  assign in_item.page            = offered_row.page;
  assign in_item.register_index  = offered_row.register_index;
  assign in_item.command_address = offered_row.command_address;
  assign in_item.data_byte       = offered_row.data_byte;
  assign in_item.run_end         = offered_row.run_end;
  assign out_word.ready          = out_ready;

  always #1 clk = ~clk;

  // Most gaps short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(12, 40);
  endfunction

  // Work out the link words for one access and advance the shadow pointers.
  // Returns the number of words; the last of them carries the last flag.
  function automatic int encode_access(input panel_access_t a, output link_exp_t [3:0] w);
    int   n;
    logic page_hit;
    logic reg_hit;
    n = 0;
    w = '0;
    page_hit = page_copy_ok && page_copy == a.page;
    reg_hit  = reg_copy_ok && reg_copy == {1'b0, a.register_index};
    case (a.operation)
      OP_INDEX_WR: begin
        // skip the index word when the panel already points there
        if (!(index_copy_ok && index_copy == {1'b0, a.index_address})) begin
          w[n] = {PFX_INDEX_ADDR, a.index_address, 2'b00};
          n++;
        end
        w[n] = {PFX_INDEX_DATA, a.data_byte, 2'b00};
        n++;
        // the copy is 16 bits wide: the top address steps to 0x8000, not to zero
        index_copy    = {1'b0, a.index_address} + 16'd1;
        index_copy_ok = 1'b1;
        reg_copy_ok   = 1'b0;
      end
      OP_PAGED_WR: begin
        // a write to the page-select register never sends the page words first
        if (!page_hit && a.register_index != REG_PAGE_SEL) begin
          w[n] = {8'h00, REG_PAGE_SEL, 2'b00};
          n++;
          w[n] = {PFX_REG_DATA, a.page, 2'b00};
          n++;
          page_copy    = a.page;
          page_copy_ok = 1'b1;
          reg_hit      = 1'b0;
        end
        if (!reg_hit) begin
          w[n] = {8'h00, a.register_index, 2'b00};
          n++;
        end
        w[n] = {PFX_REG_DATA, a.data_byte, 2'b00};
        n++;
        if (a.register_index == REG_PAGE_SEL) begin
          page_copy    = a.data_byte;
          page_copy_ok = 1'b1;
        end
        // nine bits: register 0xFF steps to 0x100 and so never matches 0x00
        reg_copy      = {1'b0, a.register_index} + 9'd1;
        reg_copy_ok   = 1'b1;
        index_copy_ok = 1'b0;
      end
      OP_DIRECT_WR: begin
        w[n] = {PFX_DIRECT_ADDR, a.command_address, 2'b00};
        n++;
        w[n] = {PFX_DIRECT_DATA, a.data_byte, 2'b00};
        n++;
        index_copy_ok = 1'b0;
        reg_copy_ok   = 1'b0;
      end
      OP_INDEX_RD: begin
        // a read always resends the index, whatever the copy says
        w[n] = {PFX_INDEX_ADDR, a.index_address, 2'b00};
        n++;
        w[n] = {WORD_INDEX_RD, 2'b10};
        n++;
        index_copy    = {1'b0, a.index_address};
        index_copy_ok = 1'b1;
        reg_copy_ok   = 1'b0;
      end
      OP_PAGED_RD: begin
        if (!page_hit) begin
          w[n] = {8'h00, REG_PAGE_SEL, 2'b00};
          n++;
          w[n] = {PFX_REG_DATA, a.page, 2'b00};
          n++;
          page_copy    = a.page;
          page_copy_ok = 1'b1;
        end
        w[n] = {8'h00, a.register_index, 2'b00};
        n++;
        w[n] = {WORD_PAGED_RD, 2'b10};
        n++;
        reg_copy      = {1'b0, a.register_index};
        reg_copy_ok   = 1'b1;
        index_copy_ok = 1'b0;
      end
      OP_INVALIDATE: begin
        index_copy_ok = 1'b0;
        page_copy_ok  = 1'b0;
        reg_copy_ok   = 1'b0;
      end
      default: begin
        // spare codes: no words, no change
      end
    endcase
    if (n > 0) w[n-1].last = 1'b1;
    return n;
  endfunction

  function automatic panel_access_t random_access();
    panel_access_t a;
    a = '0;
    a.operation       = 3'($urandom_range(0, 7));
    a.index_address   = 15'($urandom_range(0, 16'h7FFF));
    a.page            = 8'($urandom_range(0, 8'hFF));
    a.register_index  = 8'($urandom_range(0, 8'hFF));
    a.command_address = 14'($urandom_range(0, 14'h3FFF));
    a.data_byte       = 8'($urandom_range(0, 8'hFF));
    a.run_end         = 1'($urandom_range(0, 1));
    return a;
  endfunction

  // Queue an access; spare codes do not count towards the random total
  function automatic void plan_access(input panel_access_t a);
    access_plan.push_back(a);
    if (a.operation <= OP_INVALIDATE) live_words++;
  endfunction

  task automatic add_row(input logic [2:0] op, input logic [14:0] addr, input logic [7:0] pg,
                         input logic [7:0] rg, input logic [13:0] cmd, input logic [7:0] dat,
                         input logic rend);
    panel_access_t a;
    a = '0;
    a.operation       = op;
    a.index_address   = addr;
    a.page            = pg;
    a.register_index  = rg;
    a.command_address = cmd;
    a.data_byte       = dat;
    a.run_end         = rend;
    plan_access(a);
  endtask

  // Pin the link words of the last row to values read straight off the spec
  function automatic void expect_words(input int n, input logic [15:0] w0, input logic [15:0] w1,
                                       input logic [1:0] data_mask);
    panel_access_t a;
    a = access_plan[access_plan.size()-1];
    a.typed       = 1'b1;
    a.typed_count = 2'(n);
    a.typed_words = {w1, w0};
    a.typed_data  = data_mask;
    access_plan[access_plan.size()-1] = a;
  endfunction

  // Mostly well-formed runs with random content, so that the pointer copies
  // hit as often as they miss; the rest is loose noise over all codes
  task automatic add_random_burst(input logic [2:0][7:0] pool);
    panel_access_t a;
    int            kind;
    int            len;
    logic [14:0]   addr;
    logic [7:0]    pg;
    logic [7:0]    rg;
    logic [1:0]    pick;
    kind = $urandom_range(0, 99);
    len  = $urandom_range(1, 6);
    a    = random_access();
    pg   = ($urandom_range(0, 3) != 0) ? pool[$urandom_range(0, 2)] : a.page;
    pick = 2'($urandom_range(0, 3));
    if (kind < 30) begin
      // indexed run, now and then off the top of the address space
      addr = ($urandom_range(0, 3) == 0) ? 15'(15'h7FFF - $urandom_range(0, 3))
                                         : a.index_address;
      if ($urandom_range(0, 2) == 0) begin
        a.operation     = OP_INDEX_RD;
        a.index_address = addr;
        plan_access(a);
      end
      for (int k = 0; k < len; k++) begin
        a               = random_access();
        a.operation     = OP_INDEX_WR;
        a.index_address = 15'(addr + k);
        a.run_end       = (k == len - 1);
        plan_access(a);
      end
    end else if (kind < 60) begin
      // paged run, sometimes across page select or the top register
      rg = ($urandom_range(0, 3) == 0) ? {3'b111, pick[1], 3'b111, pick[0]} : a.register_index;
      for (int k = 0; k < len; k++) begin
        a                = random_access();
        a.operation      = OP_PAGED_WR;
        a.page           = pg;
        a.register_index = 8'(rg + k);
        a.run_end        = (k == len - 1);
        plan_access(a);
      end
    end else if (kind < 75) begin
      a.operation = OP_PAGED_RD;
      a.page      = pg;
      plan_access(a);
      if ($urandom_range(0, 1) == 0) begin
        rg               = a.register_index;
        a                = random_access();
        a.operation      = OP_PAGED_WR;
        a.page           = pg;
        a.register_index = rg;
        plan_access(a);
      end
    end else if (kind < 85) begin
      a.operation = OP_DIRECT_WR;
      plan_access(a);
    end else if (kind < 90) begin
      a.operation = OP_INVALIDATE;
      plan_access(a);
    end else begin
      plan_access(a);
    end
  endtask

  // Cycle count and watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Link side: stall in bursts, with calm phases where ready stays high
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (((cycles / 150) % 4) >= 2 && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  // Predict on every accepted input word, check every accepted link word
  always @(posedge clk) begin : track_link
    link_exp_t [3:0] plan;
    link_exp_t       got;
    link_exp_t       due;
    int              n;
    if (rst_n) begin
      if (in_valid && in_item.ready) begin
        n = encode_access(offered_row, plan);
        if (offered_row.typed) begin
          n = offered_row.typed_count;
          for (int k = 0; k < n; k++)
            plan[k] = {offered_row.typed_words[k], offered_row.typed_data[k], k == n - 1};
        end
        for (int k = 0; k < n; k++) link_words_due.push_back(plan[k]);
      end
      if (out_word.valid && out_ready) begin
        got = {out_word.link_word, out_word.reply_is_data, out_word.last};
        if (link_words_due.size() == 0) begin
          $error("link word %h taken with nothing due", got.word);
          mismatches++;
        end else begin
          due = link_words_due.pop_front();
          if (got.word !== due.word) begin
            $error("link_word: expected %h, got %h", due.word, got.word);
            mismatches++;
          end
          if (got.reply_is_data !== due.reply_is_data) begin
            $error("reply_is_data: expected %b, got %b", due.reply_is_data, got.reply_is_data);
            mismatches++;
          end
          if (got.last !== due.last) begin
            $error("last: expected %b, got %b", due.last, got.last);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin : drive_words
    logic [2:0][7:0] pool;
    int              gap;
    int              directed_rows;
    int              directed_live;
    logic            hold;

    // Directed table. Rows with words pinned by hand are the easy ones:
    // straight after reset, field extremes and the do-nothing codes.
    add_row(OP_INDEX_WR, 15'h7FFF, 8'h00, 8'h00, 14'h0000, 8'hFF, 1'b0);
    expect_words(2, 16'hFFFF, 16'h81FF, 2'b00);
    // index copy now 0x8000, so address zero must resend the index
    add_row(OP_INDEX_WR, 15'h0000, 8'hFF, 8'hFF, 14'h3FFF, 8'h00, 1'b1);
    expect_words(2, 16'h8000, 16'h8100, 2'b00);
    add_row(OP_INDEX_WR, 15'h0001, 8'h00, 8'h00, 14'h0000, 8'h5A, 1'b0);
    expect_words(1, 16'h815A, 16'h0000, 2'b00);
    add_row(OP_INDEX_RD, 15'h0002, 8'h00, 8'h00, 14'h0000, 8'h00, 1'b0);
    expect_words(2, 16'h8002, 16'hA000, 2'b10);
    // a read leaves the index in place rather than stepping it
    add_row(OP_INDEX_WR, 15'h0002, 8'h00, 8'h00, 14'h0000, 8'hA5, 1'b1);
    expect_words(1, 16'h81A5, 16'h0000, 2'b00);
    add_row(OP_DIRECT_WR, 15'h0000, 8'h00, 8'h00, 14'h3FFF, 8'hFF, 1'b0);
    expect_words(2, 16'hFFFF, 16'hC1FF, 2'b00);
    add_row(OP_DIRECT_WR, 15'h7FFF, 8'hFF, 8'hFF, 14'h0000, 8'h00, 1'b1);
    expect_words(2, 16'hC000, 16'hC100, 2'b00);
    // direct writes drop the index copy
    add_row(OP_INDEX_WR, 15'h0003, 8'h00, 8'h00, 14'h0000, 8'h00, 1'b0);
    expect_words(2, 16'h8003, 16'h8100, 2'b00);
    // paged sequences: miss, hit, page change, page-select register, 9-bit wrap
    add_row(OP_PAGED_WR, 15'h7FFF, 8'hFF, 8'h00, 14'h3FFF, 8'h11, 1'b0);
    add_row(OP_PAGED_WR, 15'h0000, 8'hFF, 8'h01, 14'h0000, 8'h22, 1'b1);
    add_row(OP_PAGED_WR, 15'h0000, 8'h00, 8'h02, 14'h0000, 8'h33, 1'b0);
    add_row(OP_PAGED_WR, 15'h0000, 8'h07, REG_PAGE_SEL, 14'h0000, 8'h40, 1'b0);
    add_row(OP_PAGED_WR, 15'h0000, 8'h40, 8'hF0, 14'h0000, 8'h01, 1'b1);
    add_row(OP_PAGED_WR, 15'h0000, 8'h40, 8'hFF, 14'h0000, 8'hFF, 1'b0);
    add_row(OP_PAGED_WR, 15'h0000, 8'h40, 8'h00, 14'h0000, 8'h00, 1'b1);
    add_row(OP_PAGED_RD, 15'h0000, 8'h40, 8'h01, 14'h0000, 8'h00, 1'b0);
    add_row(OP_PAGED_WR, 15'h0000, 8'h40, 8'h01, 14'h0000, 8'h9C, 1'b0);
    // no page-select exception on a read
    add_row(OP_PAGED_RD, 15'h0000, 8'h00, REG_PAGE_SEL, 14'h0000, 8'h00, 1'b0);
    add_row(OP_INDEX_WR, 15'h0010, 8'h00, 8'h00, 14'h0000, 8'h77, 1'b1);
    add_row(OP_INVALIDATE, 15'h7FFF, 8'hFF, 8'hFF, 14'h3FFF, 8'hFF, 1'b1);
    expect_words(0, 16'h0000, 16'h0000, 2'b00);
    add_row(OP_PAGED_RD, 15'h0000, 8'h00, 8'h10, 14'h0000, 8'h00, 1'b0);
    add_row(OP_SPARE_6, 15'h7FFF, 8'hFF, 8'hFF, 14'h3FFF, 8'hFF, 1'b1);
    expect_words(0, 16'h0000, 16'h0000, 2'b00);
    add_row(OP_SPARE_7, 15'h5555, 8'hAA, 8'h55, 14'h2AAA, 8'hAA, 1'b0);
    expect_words(0, 16'h0000, 16'h0000, 2'b00);
    // direct write keeps the page copy
    add_row(OP_DIRECT_WR, 15'h0000, 8'h00, 8'h00, 14'h1555, 8'hAA, 1'b0);
    add_row(OP_PAGED_RD, 15'h0000, 8'h00, 8'h20, 14'h0000, 8'h00, 1'b0);
    directed_rows = access_plan.size();
    directed_live = live_words;

    pool = 24'($urandom());
    while (live_words < directed_live + RANDOM_WORDS) add_random_burst(pool);

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    foreach (access_plan[i]) begin
      // drain the link fully at the end of the table and once mid-way
      hold = (i == directed_rows) || (i == directed_rows + 140);
      gap  = 0;
      if (((cycles / 150) % 4) != 1 && $urandom_range(0, 2) == 0) gap = pick_gap();
      if (hold && gap == 0) gap = 1;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
        if (hold)
          while (link_words_due.size() != 0) @(negedge clk);
      end
      offered_row <= access_plan[i];
      in_valid    <= 1'b1;
      do @(posedge clk); while (!in_item.ready);
      @(negedge clk);
    end
    in_valid <= 1'b0;

    while (link_words_due.size() != 0) @(negedge clk);
    // let any stray words surface before the verdict
    repeat (16) @(negedge clk);
    if (mismatches == 0 && link_words_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[files.f]
src/dlce_pkg.sv
src/dlce_if.sv
src/dlce_fifo.sv
src/dlce_front.sv
src/dlce_back.sv
src/display_link_command_encoder_unit.sv
tb/display_link_command_encoder_unit_tb.sv
